### hdl/dnd_pkg.sv
// Shared types, codes and constants of the DNS name decompressor.
// Depends on nothing; the walker, output register, top level and testbench import it.
`default_nettype none

package dnd_pkg;

    localparam int DEF_BUF_DEPTH      = 1024;
    localparam int DEF_MAX_NAME_CHARS = 255;

    localparam logic [1:0] PTR_TAG  = 2'b11;
    localparam logic [7:0] DOT_CHAR = 8'h2E;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef enum logic [2:0] {
        ERR_OK         = 3'd0,
        ERR_NO_INPUT   = 3'd1,
        ERR_BAD_HEADER = 3'd2,
        ERR_BAD_PTR    = 3'd3,
        ERR_OVERRUN    = 3'd4,
        ERR_EMPTY      = 3'd5,
        ERR_TOO_LONG   = 3'd6
    } dnd_err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_PTR,
        ST_LABEL,
        ST_EMIT,
        ST_OUT,
        ST_FINAL
    } dnd_state_t;

    typedef struct packed {
        logic        mode;
        logic [9:0]  address;
        logic [7:0]  data_byte;
        logic [10:0] packet_length;
    } dnd_req_t;

    typedef struct packed {
        logic [63:0] name_chars;
        logic [3:0]  char_count;
        logic        last;
        logic [10:0] end_position;
        logic [2:0]  error_code;
    } dnd_res_t;

    typedef struct packed {
        logic     load;
        dnd_res_t res;
    } dnd_res_load_t;

endpackage

`default_nettype wire

### hdl/dnd_ram.sv
// Byte-wide synchronous RAM: one write port, one read port, registered read data.
// Depends on nothing; holds the packet buffer and the name buffer.
`default_nettype none

module dnd_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output      logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/dnd_out_reg.sv
// Result output register that parts the walker from the result receiver.
// Depends on dnd_pkg for the result types.
`default_nettype none

module dnd_out_reg (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dnd_pkg::dnd_res_load_t res_load,
    output      logic                  res_free,
    output      logic                  res_valid,
    input  wire logic                  res_stall,
    output      dnd_pkg::dnd_res_t     res_data
);

    import dnd_pkg::*;

    logic     valid_reg;
    dnd_res_t data_reg;

    // hold a result until the receiver takes it
    assign res_free  = !valid_reg || !res_stall;
    assign res_valid = valid_reg;
    assign res_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_load.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load.load)
        begin
            data_reg <= res_load.res;
        end
    end

endmodule

`default_nettype wire

### hdl/dnd_walker.sv
// Name walker: loads the packet buffer, walks labels and pointers, fills the
// name buffer and streams chunks. Depends on dnd_pkg.
`default_nettype none

module dnd_walker #(
    parameter int BUF_DEPTH      = 1024,
    parameter int MAX_NAME_CHARS = 255,
    parameter int AW             = $clog2(BUF_DEPTH),
    parameter int NIW            = $clog2(MAX_NAME_CHARS)
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output      logic                   req_stall,
    input  wire dnd_pkg::dnd_req_t      req_data,
    output      logic                   pkt_we,
    output      logic [AW-1:0]          pkt_waddr,
    output      logic [7:0]             pkt_wdata,
    output      logic                   pkt_re,
    output      logic [AW-1:0]          pkt_raddr,
    input  wire logic [7:0]             pkt_rdata,
    output      logic                   name_we,
    output      logic [NIW-1:0]         name_waddr,
    output      logic [7:0]             name_wdata,
    output      logic                   name_re,
    output      logic [NIW-1:0]         name_raddr,
    input  wire logic [7:0]             name_rdata,
    input  wire logic                   res_free,
    output      dnd_pkg::dnd_res_load_t res_load
);

    import dnd_pkg::*;

    localparam int PW  = (AW + 1 > 7) ? AW + 1 : 7;
    localparam int LW  = $clog2(MAX_NAME_CHARS + 1);
    localparam int LW1 = LW + 1;

    dnd_state_t     state_reg, state_next;
    logic [PW-1:0]  cur_reg, cur_next;
    logic [PW-1:0]  lowest_reg, lowest_next;
    logic [PW-1:0]  plen_reg, plen_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic           jumped_reg, jumped_next;
    logic [LW-1:0]  len_reg, len_next;
    logic [5:0]     cnt_reg, cnt_next;
    logic [5:0]     hi_reg, hi_next;
    logic [LW-1:0]  ridx_reg, ridx_next;
    logic [63:0]    chunk_reg, chunk_next;
    dnd_err_t       err_reg, err_next;

    logic           accept;
    logic           dec_start;
    logic [PW-1:0]  plen_in;
    logic           start_bad;
    logic [5:0]     b6;
    logic           is_end, is_ptr, is_bad;
    logic [PW-1:0]  cur_inc;
    logic           ptr_short;
    logic [PW-1:0]  label_end;
    logic           overrun;
    logic [LW1-1:0] len_add;
    logic           too_long;
    logic [13:0]    tgt;
    logic           tgt_bad;
    logic [LW-1:0]  ridx_inc;
    logic           name_last;
    logic           chunk_end;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign dec_start = accept && (req_data.mode == MODE_DECODE);

    // clamp the packet length to the buffer
    assign plen_in   = (32'(req_data.packet_length) > BUF_DEPTH) ? PW'(BUF_DEPTH)
                                                               : PW'(req_data.packet_length);
    assign start_bad = 32'(req_data.address) >= 32'(plen_in);

    assign b6        = pkt_rdata[5:0];
    assign is_end    = (pkt_rdata == 8'h00);
    assign is_ptr    = (pkt_rdata[7:6] == PTR_TAG);
    assign is_bad    = (pkt_rdata[7:6] != PTR_TAG) && (pkt_rdata[7:6] != 2'b00);
    assign cur_inc   = cur_reg + PW'(1);
    assign ptr_short = (cur_inc >= plen_reg);
    assign label_end = cur_reg + PW'(b6) + PW'(1);
    assign overrun   = (label_end >= plen_reg);
    assign len_add   = LW1'(len_reg) + LW1'(b6) + LW1'(len_reg != '0);
    assign too_long  = 32'(len_add) > MAX_NAME_CHARS;
    assign tgt       = {hi_reg, pkt_rdata};
    assign tgt_bad   = 32'(tgt) >= 32'(lowest_reg);
    assign ridx_inc  = ridx_reg + LW'(1);
    assign name_last = (ridx_inc == len_reg);
    assign chunk_end = (ridx_reg[2:0] == 3'd7) || name_last;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (dec_start)
                begin
                    state_next = start_bad ? ST_FINAL : ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (is_end)
                begin
                    state_next = (len_reg == '0) ? ST_FINAL : ST_EMIT;
                end
                else if (is_bad)
                begin
                    state_next = ST_FINAL;
                end
                else if (is_ptr)
                begin
                    state_next = ptr_short ? ST_FINAL : ST_PTR;
                end
                else
                begin
                    state_next = (overrun || too_long) ? ST_FINAL : ST_LABEL;
                end
            end
            ST_PTR:
            begin
                state_next = tgt_bad ? ST_FINAL : ST_LEN;
            end
            ST_LABEL:
            begin
                if (cnt_reg == 6'd1)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_EMIT:
            begin
                if (chunk_end)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (res_free)
                begin
                    state_next = name_last ? ST_FINAL : ST_EMIT;
                end
            end
            ST_FINAL:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory ports and result loads
    always_comb
    begin
        pkt_we     = accept && (req_data.mode == MODE_WRITE)
                     && (32'(req_data.address) < BUF_DEPTH);
        pkt_waddr  = AW'(req_data.address);
        pkt_wdata  = req_data.data_byte;
        pkt_re     = 1'b0;
        pkt_raddr  = AW'(cur_inc);
        name_we    = 1'b0;
        name_waddr = NIW'(len_reg);
        name_wdata = pkt_rdata;
        name_re    = 1'b0;
        name_raddr = NIW'(ridx_inc);
        res_load   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pkt_re    = dec_start && !start_bad;
                pkt_raddr = AW'(req_data.address);
            end
            ST_LEN:
            begin
                if (is_end)
                begin
                    name_re    = (len_reg != '0);
                    name_raddr = '0;
                end
                else if (is_ptr)
                begin
                    pkt_re = !ptr_short;
                end
                else if (!is_bad)
                begin
                    pkt_re     = !(overrun || too_long);
                    name_we    = !(overrun || too_long) && (len_reg != '0);
                    name_wdata = DOT_CHAR;
                end
            end
            ST_PTR:
            begin
                pkt_re    = !tgt_bad;
                pkt_raddr = AW'(tgt);
            end
            ST_LABEL:
            begin
                pkt_re  = 1'b1;
                name_we = 1'b1;
            end
            ST_EMIT:
            begin
                name_re = !chunk_end;
            end
            ST_OUT:
            begin
                name_re                 = res_free && !name_last;
                res_load.load           = res_free;
                res_load.res.name_chars = chunk_reg;
                res_load.res.char_count = 4'(ridx_reg[2:0]) + 4'd1;
            end
            ST_FINAL:
            begin
                res_load.load             = res_free;
                res_load.res.last         = 1'b1;
                res_load.res.error_code   = err_reg;
                res_load.res.end_position = (err_reg == ERR_OK) ? 11'(cur_pos_end(pos_reg)) : '0;
            end
            default:
            begin
                pkt_re = 1'b0;
            end
        endcase
    end

    function automatic logic [PW-1:0] cur_pos_end(input logic [PW-1:0] p);
        cur_pos_end = p + PW'(1);
    endfunction

    // walk registers
    always_comb
    begin
        cur_next    = cur_reg;
        lowest_next = lowest_reg;
        plen_next   = plen_reg;
        pos_next    = pos_reg;
        jumped_next = jumped_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        hi_next     = hi_reg;
        ridx_next   = ridx_reg;
        chunk_next  = chunk_reg;
        err_next    = err_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (dec_start)
                begin
                    cur_next    = PW'(req_data.address);
                    pos_next    = PW'(req_data.address);
                    plen_next   = plen_in;
                    lowest_next = plen_in;
                    jumped_next = 1'b0;
                    len_next    = '0;
                    err_next    = start_bad ? ERR_NO_INPUT : ERR_OK;
                end
            end
            ST_LEN:
            begin
                if (is_end)
                begin
                    ridx_next  = '0;
                    chunk_next = '0;
                    if (len_reg == '0)
                    begin
                        err_next = ERR_EMPTY;
                    end
                end
                else if (is_bad)
                begin
                    err_next = ERR_BAD_HEADER;
                end
                else if (is_ptr)
                begin
                    if (ptr_short)
                    begin
                        err_next = ERR_BAD_HEADER;
                    end
                    else
                    begin
                        hi_next = b6;
                        if (!jumped_reg)
                        begin
                            pos_next    = cur_inc;
                            jumped_next = 1'b1;
                        end
                    end
                end
                else if (overrun)
                begin
                    err_next = ERR_OVERRUN;
                end
                else if (too_long)
                begin
                    err_next = ERR_TOO_LONG;
                end
                else
                begin
                    cnt_next = b6;
                    cur_next = cur_inc;
                    if (len_reg != '0)
                    begin
                        len_next = len_reg + LW'(1);
                    end
                end
            end
            ST_PTR:
            begin
                if (tgt_bad)
                begin
                    err_next = ERR_BAD_PTR;
                end
                else
                begin
                    cur_next    = PW'(tgt);
                    lowest_next = PW'(tgt);
                end
            end
            ST_LABEL:
            begin
                len_next = len_reg + LW'(1);
                cnt_next = cnt_reg - 6'd1;
                cur_next = cur_inc;
                if ((cnt_reg == 6'd1) && !jumped_reg)
                begin
                    pos_next = cur_inc;
                end
            end
            ST_EMIT:
            begin
                chunk_next[{ridx_reg[2:0], 3'b000} +: 8] = name_rdata;
                if (!chunk_end)
                begin
                    ridx_next = ridx_inc;
                end
            end
            ST_OUT:
            begin
                if (res_free)
                begin
                    chunk_next = '0;
                    if (!name_last)
                    begin
                        ridx_next = ridx_inc;
                    end
                end
            end
            default:
            begin
                err_next = err_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cur_reg    <= '0;
            lowest_reg <= '0;
            plen_reg   <= '0;
            pos_reg    <= '0;
            jumped_reg <= 1'b0;
            len_reg    <= '0;
            cnt_reg    <= '0;
            hi_reg     <= '0;
            ridx_reg   <= '0;
            chunk_reg  <= '0;
            err_reg    <= ERR_OK;
        end
        else
        begin
            state_reg  <= state_next;
            cur_reg    <= cur_next;
            lowest_reg <= lowest_next;
            plen_reg   <= plen_next;
            pos_reg    <= pos_next;
            jumped_reg <= jumped_next;
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
            hi_reg     <= hi_next;
            ridx_reg   <= ridx_next;
            chunk_reg  <= chunk_next;
            err_reg    <= err_next;
        end
    end

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_load.load |-> res_free)
        else $error("result loaded while output register is still held");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(len_reg) <= MAX_NAME_CHARS)
        else $error("name length passed the limit");

    a_label_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LABEL) |-> (cnt_reg != 6'd0))
        else $error("label copy running with no bytes left");

    a_lowest_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (lowest_reg <= plen_reg))
        else $error("pointer floor above packet length");

    a_final_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_OUT) && res_free && name_last) |=> (state_reg == ST_FINAL))
        else $error("last chunk not followed by the final result");
`endif

endmodule

`default_nettype wire

### hdl/dns_name_decompressor_top.sv
// Top level of the DNS name decompressor: packet buffer, name buffer, walker
// and output register. Depends on dnd_pkg, dnd_ram, dnd_walker, dnd_out_reg.
//
// Usage:
//   Request channel (req_valid/req_stall/req_data): mode 0 stores data_byte at
//   address in the packet buffer (addresses past BUF_DEPTH are dropped); mode 1
//   decodes the name that starts at address, bounded by packet_length.
//   Result channel (res_valid/res_stall/res_data): a good decode gives one
//   chunk of up to eight characters per result, then a final result with last
//   set and end_position; a failed decode gives only the final result with its
//   error_code.
//   A decode walks the length bytes, label characters and pointers, reading
//   the packet buffer as it goes, then reads the name buffer out chunk by
//   chunk and ends with the final result. One request is decoded at a time;
//   req_stall stays high until the final result is in the output register.
//   Reset clears the control state; the buffers hold garbage until written and
//   need no clearing pass. A stalled receiver holds the output register and
//   the walker waits before its next result load.
`default_nettype none

module dns_name_decompressor_top #(
    parameter int BUF_DEPTH      = dnd_pkg::DEF_BUF_DEPTH,
    parameter int MAX_NAME_CHARS = dnd_pkg::DEF_MAX_NAME_CHARS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output      logic              req_stall,
    input  wire dnd_pkg::dnd_req_t req_data,
    output      logic              res_valid,
    input  wire logic              res_stall,
    output      dnd_pkg::dnd_res_t res_data
);

    import dnd_pkg::*;

    localparam int AW  = $clog2(BUF_DEPTH);
    localparam int NIW = $clog2(MAX_NAME_CHARS);

    // packet buffer port
    logic          pkt_we;
    logic [AW-1:0] pkt_waddr;
    logic [7:0]    pkt_wdata;
    logic          pkt_re;
    logic [AW-1:0] pkt_raddr;
    logic [7:0]    pkt_rdata;

    // name buffer port
    logic           name_we;
    logic [NIW-1:0] name_waddr;
    logic [7:0]     name_wdata;
    logic           name_re;
    logic [NIW-1:0] name_raddr;
    logic [7:0]     name_rdata;

    dnd_res_load_t res_load;
    logic          res_free;

    // Packet bytes; writes happen only while the walker is idle, so reads
    // and writes never meet on the same entry.
    dnd_ram #(
        .DEPTH (BUF_DEPTH),
        .AW    (AW)
    ) u_pkt_ram (
        .clk   (clk),
        .we    (pkt_we),
        .waddr (pkt_waddr),
        .wdata (pkt_wdata),
        .re    (pkt_re),
        .raddr (pkt_raddr),
        .rdata (pkt_rdata)
    );

    // Decoded name; filled during the walk and read back only after it ends.
    dnd_ram #(
        .DEPTH (MAX_NAME_CHARS),
        .AW    (NIW)
    ) u_name_ram (
        .clk   (clk),
        .we    (name_we),
        .waddr (name_waddr),
        .wdata (name_wdata),
        .re    (name_re),
        .raddr (name_raddr),
        .rdata (name_rdata)
    );

    dnd_walker #(
        .BUF_DEPTH      (BUF_DEPTH),
        .MAX_NAME_CHARS (MAX_NAME_CHARS),
        .AW             (AW),
        .NIW            (NIW)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .pkt_we     (pkt_we),
        .pkt_waddr  (pkt_waddr),
        .pkt_wdata  (pkt_wdata),
        .pkt_re     (pkt_re),
        .pkt_raddr  (pkt_raddr),
        .pkt_rdata  (pkt_rdata),
        .name_we    (name_we),
        .name_waddr (name_waddr),
        .name_wdata (name_wdata),
        .name_re    (name_re),
        .name_raddr (name_raddr),
        .name_rdata (name_rdata),
        .res_free   (res_free),
        .res_load   (res_load)
    );

    // Hold each result here until the receiver takes it.
    dnd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_load  (res_load),
        .res_free  (res_free),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

`default_nettype wire

### tb/dns_name_decompressor_top_test.sv
// Self-checking testbench for dns_name_decompressor_top: a scoreboard class
// predicts each decode from its own copy of the packet buffer.
// Depends on dnd_pkg and the dns_name_decompressor_top RTL; needs nothing else.

module dns_name_decompressor_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import dnd_pkg::*;

    // Scoreboard: mirrors the packet buffer, expands every accepted decode
    // request into its chunks plus final result, and checks results in order.
    class name_scoreboard;
        logic [7:0] pkt_mem [DEF_BUF_DEPTH];
        dnd_res_t   expected_q [$];
        int         errors;
        int         decodes;
        int         writes;
        int         checked;
        int         outcome [0:6];

        function void note_request(dnd_req_t r);
            int unsigned plen;
            int unsigned cur;
            int unsigned lowest;
            int unsigned pos;
            int unsigned tgt;
            logic [7:0]  lb;
            logic [7:0]  text [$];
            bit          jumped;
            dnd_err_t    err;
            dnd_res_t    res;

            if (r.mode == MODE_WRITE) begin
                pkt_mem[r.address] = r.data_byte;
                writes++;
                return;
            end
            decodes++;
            plen   = (r.packet_length > DEF_BUF_DEPTH) ? DEF_BUF_DEPTH : r.packet_length;
            cur    = r.address;
            lowest = plen;
            pos    = cur;
            jumped = 1'b0;
            err    = ERR_OK;
            if (cur >= plen)
                err = ERR_NO_INPUT;
            while (err == ERR_OK) begin
                lb = pkt_mem[cur];
                if (lb == 8'h00)
                    break;
                if (lb[7:6] == PTR_TAG) begin
                    if (cur + 1 >= plen)
                        err = ERR_BAD_HEADER;
                    else begin
                        if (!jumped) begin
                            pos    = cur + 1;
                            jumped = 1'b1;
                        end
                        tgt = {lb[5:0], pkt_mem[cur + 1]};
                        if (tgt >= lowest)
                            err = ERR_BAD_PTR;
                        else begin
                            cur    = tgt;
                            lowest = tgt;
                        end
                    end
                end else if (lb[7:6] != 2'b00)
                    err = ERR_BAD_HEADER;
                else if (cur + lb + 1 >= plen)
                    err = ERR_OVERRUN;
                else if (text.size() + lb + (text.size() > 0) > DEF_MAX_NAME_CHARS)
                    err = ERR_TOO_LONG;
                else begin
                    if (text.size() > 0)
                        text.push_back(DOT_CHAR);
                    for (int i = 1; i <= lb; i++)
                        text.push_back(pkt_mem[cur + i]);
                    cur = cur + lb + 1;
                    if (!jumped)
                        pos = cur;
                end
            end
            if (err == ERR_OK && text.size() == 0)
                err = ERR_EMPTY;
            outcome[int'(err)]++;

            if (err == ERR_OK) begin
                for (int i = 0; i < text.size(); i += 8) begin
                    res = '0;
                    for (int j = 0; j < 8 && i + j < text.size(); j++)
                        res.name_chars[8*j +: 8] = text[i + j];
                    res.char_count = (text.size() - i > 8) ? 4'd8 : 4'(text.size() - i);
                    expected_q.push_back(res);
                end
            end
            res = '0;
            res.last = 1'b1;
            res.error_code = err;
            if (err == ERR_OK)
                res.end_position = 11'(pos + 1);
            expected_q.push_back(res);
        endfunction

        function void report(string field, logic [63:0] want, logic [63:0] got);
            errors++;
            $display("%0t: %s expected %h actual %h", $time, field, want, got);
        endfunction

        function void check_result(dnd_res_t got);
            dnd_res_t want;

            checked++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result expected none actual %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.name_chars !== want.name_chars)
                report("name_chars", want.name_chars, got.name_chars);
            if (got.char_count !== want.char_count)
                report("char_count", 64'(want.char_count), 64'(got.char_count));
            if (got.last !== want.last)
                report("last", 64'(want.last), 64'(got.last));
            if (got.end_position !== want.end_position)
                report("end_position", 64'(want.end_position), 64'(got.end_position));
            if (got.error_code !== want.error_code)
                report("error_code", 64'(want.error_code), 64'(got.error_code));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    dnd_req_t req_data;
    logic     res_valid;
    logic     res_stall;
    dnd_res_t res_data;

    name_scoreboard sb = new();

    // Idling controls shared by the sender and the receiver.
    bit quiet     = 1'b0;   // no gaps and no stalls for the closing stretch
    bit long_hold = 1'b0;   // ask the receiver for one long hold-off

    // Starts of names laid down so far; random pointers mostly aim here.
    int name_starts [$];

    dns_name_decompressor_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard limit on run time: well above the slowest correct run.
    initial
    begin
        #30_000_000;
        $display("timeout at %0t, %0d results still pending", $time, sb.pending());
        $display("end of test: mismatches");
        $finish;
    end

    // Receiver: stall in random bursts, once hold off long enough that the
    // block fills up and stalls the request side, and never stall when quiet.
    initial
    begin
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                long_hold = 1'b0;
                res_stall <= 1'b1;
                repeat (400) @(posedge clk);
                res_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    // Check every result taken at a clock edge.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res_data);
    end

    // Offer one request, optionally after a gap, and hold it until taken.
    // Valid stays high into the next request unless that one takes a gap.
    task automatic send_req(input dnd_req_t r);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic put_byte(input int a, input logic [7:0] d);
        dnd_req_t r;

        r.mode          = MODE_WRITE;
        r.address       = a[9:0];
        r.data_byte     = d;
        r.packet_length = 11'($urandom_range(0, 2047));
        send_req(r);
    endtask

    task automatic put_bytes(input int a, input logic [7:0] bq [$]);
        foreach (bq[i])
            put_byte(a + i, bq[i]);
    endtask

    task automatic run_decode(input int a, input int plen);
        dnd_req_t r;

        r.mode          = MODE_DECODE;
        r.address       = a[9:0];
        r.data_byte     = 8'($urandom_range(0, 255));
        r.packet_length = plen[10:0];
        send_req(r);
    endtask

    // Lay down a well-formed name with random content at a random spot,
    // ended by a zero byte or a pointer, then decode it. Most packet lengths
    // cover the whole name; the rest cut it short.
    task automatic name_round();
        int base;
        int a;
        int n;
        int tgt;
        int plen;

        base = $urandom_range(420, 765);
        a = base;
        repeat ($urandom_range(1, 4))
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 63) : $urandom_range(1, 12);
            put_byte(a, 8'(n));
            a++;
            repeat (n)
            begin
                put_byte(a, 8'($urandom_range(0, 255)));
                a++;
            end
        end
        if ($urandom_range(0, 2) == 0)
        begin
            if ($urandom_range(0, 9) == 0)
                tgt = $urandom_range(0, 16383);
            else
                tgt = name_starts[$urandom_range(0, name_starts.size() - 1)];
            put_byte(a, {PTR_TAG, tgt[13:8]});
            put_byte(a + 1, tgt[7:0]);
            a += 2;
        end
        else
        begin
            put_byte(a, 8'h00);
            a++;
        end
        name_starts.push_back(base);
        if ($urandom_range(0, 9) < 7)
            plen = $urandom_range(a, 2047);
        else
            plen = $urandom_range(0, a - 1);
        run_decode(base, plen);
    endtask

    initial
    begin
        logic [7:0] bq [$];
        int         kind;
        bit         held;

        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_data  <= '0;
        held = 1'b0;
        name_starts = '{0, 143, 600, 610, 620};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole buffer so no decode can read a byte never written.
        // The low region is a run of 63-byte labels ('?' text) ended by a
        // zero at 399: from 143 it is exactly the longest legal name, from 0
        // it is one label too long.
        for (int a = 0; a < DEF_BUF_DEPTH; a++)
        begin
            if (a < 399)
                put_byte(a, 8'h3F);
            else if (a == 399)
                put_byte(a, 8'h00);
            else
                put_byte(a, 8'($urandom_range(0, 255)));
        end

        // Directed packets: broken headers, pointer faults, empty names,
        // a chain of descending pointers, chunk boundaries, extreme bytes.
        put_byte(500, 8'h80);
        put_byte(501, 8'h40);
        put_byte(510, 8'hC0);
        bq = '{8'hFF, 8'hFF};                       put_bytes(520, bq);
        bq = '{8'hC2, 8'h12};                       put_bytes(530, bq);
        bq = '{8'h00, 8'hC2, 8'h1C};                put_bytes(540, bq);
        bq = '{8'h03, "a", "b", "c", 8'h00};        put_bytes(600, bq);
        bq = '{8'h02, "x", "y", 8'hC2, 8'h58};      put_bytes(610, bq);
        bq = '{8'h01, "z", 8'hC2, 8'h62};           put_bytes(620, bq);
        bq = '{8'hC2, 8'h9A};                       put_bytes(662, bq);
        put_byte(666, 8'h00);
        bq = '{8'hC2, 8'h96};                       put_bytes(670, bq);
        bq = '{8'h08, "a", "b", "c", "d", "e", "f", "g", "h", 8'h00};
        put_bytes(680, bq);
        bq = '{8'h09, 8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h7F, 8'h2E, 8'h3F, 8'hC0, 8'h00};
        put_bytes(690, bq);
        bq = '{8'hC3, 8'h84};                       put_bytes(730, bq);

        run_decode(0, 0);           // start at the packet length
        run_decode(1023, 1023);     // start at the top of the buffer
        run_decode(500, 1024);      // upper header bit alone
        run_decode(501, 1024);      // lower header bit alone
        run_decode(510, 511);       // pointer cut off by the packet length
        run_decode(520, 1024);      // pointer target far beyond the buffer
        run_decode(530, 1024);      // pointer to itself
        run_decode(670, 1024);      // second pointer jumps forward
        run_decode(730, 800);       // pointer target past the packet length
        run_decode(540, 1024);      // empty name
        run_decode(541, 1024);      // pointer to an empty name
        run_decode(600, 1024);      // plain name
        run_decode(610, 1024);      // one pointer
        run_decode(620, 2047);      // two descending pointers, length saturates
        run_decode(620, 624);       // pointer chain just inside the packet
        run_decode(620, 623);       // pointer second byte at the packet length
        run_decode(680, 1024);      // exactly one full chunk
        run_decode(690, 1024);      // chunk plus one, extreme byte values
        run_decode(143, 2047);      // longest legal name
        run_decode(143, 1024);
        run_decode(0, 1024);        // one label too many
        run_decode(0, 300);         // overrun wins over the length limit

        // Random part: mostly well-formed names, some raw decodes at random positions
        // or at known name starts with random lengths, some stray writes.
        while (sb.decodes < 180)
        begin
            if (!held && sb.decodes >= 70)
            begin
                held = 1'b1;
                long_hold = 1'b1;
            end
            if (sb.decodes >= 155)
                quiet = 1'b1;
            kind = $urandom_range(0, 99);
            if (kind < 65)
                name_round();
            else if (kind < 78)
                run_decode($urandom_range(0, 1023), $urandom_range(0, 2047));
            else if (kind < 88)
                run_decode(name_starts[$urandom_range(0, name_starts.size() - 1)],
                           $urandom_range(0, 2047));
            else
                repeat ($urandom_range(1, 4))
                    put_byte($urandom_range(0, 1023), 8'($urandom_range(0, 255)));
        end
        req_valid <= 1'b0;

        // Drain outstanding results, then give the block time to show any
        // stray extra output.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);

        $display("covered %0d decodes and %0d byte writes, %0d results checked",
                 sb.decodes, sb.writes, sb.checked);
        $display("outcomes: ok %0d, no input %0d, header %0d, pointer %0d, overrun %0d, empty %0d, long %0d",
                 sb.outcome[0], sb.outcome[1], sb.outcome[2], sb.outcome[3],
                 sb.outcome[4], sb.outcome[5], sb.outcome[6]);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
